### rtl/core/bagn_pkg.sv
// Shared types and constants for the block ack/nack receiver.
package bagn_pkg;

    localparam int SEQ_W   = 32;
    localparam int ID_W    = 8;
    localparam int RESP_W  = SEQ_W + 1;
    localparam int GAP_W   = 8;
    localparam int TMO_W   = 16;
    localparam int DRAIN_W = 4;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [GAP_W-1:0]   GAP_RESET     = 8'd50;
    localparam logic [TMO_W-1:0]   TIMEOUT_RESET = 16'd100;
    localparam logic [DRAIN_W-1:0] DRAIN_RESET   = 4'd5;
    localparam logic [ID_W-1:0]    TARGET_RESET  = 8'd0;
    localparam logic [DRAIN_W-1:0] MAX_DRAIN     = 4'd8;
    localparam logic [TMO_W-1:0]   IDLE_MAX      = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_DATA      = 2'd0,
        OP_HEARTBEAT = 2'd1,
        OP_DRAIN     = 2'd2,
        OP_IDLE_TICK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ARM_UNKNOWN  = 2'd0,
        ARM_ARMED    = 2'd1,
        ARM_DISARMED = 2'd2
    } arm_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAP     = 2'd0,
        CFG_TIMEOUT = 2'd1,
        CFG_DRAIN   = 2'd2,
        CFG_TARGET  = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DATA,
        S_GAP,
        S_NACK,
        S_HEARTBEAT,
        S_TICK,
        S_DRAIN_SETUP,
        S_DRAIN_RD,
        S_DRAIN_LOAD
    } state_t;

    typedef struct packed {
        logic latch;
        logic data_exec;
        logic gap_exec;
        logic nack_push;
        logic hb_exec;
        logic tick_exec;
        logic drain_setup;
        logic drain_read;
        logic drain_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic data_skip;
        logic nack_go;
        logic nack_more;
        logic drain_zero;
        logic drain_more;
        logic out_free;
    } dp_stat_t;

endpackage

### rtl/core/bagn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bagn_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/bagn_ctrl.sv
// Sequencing state machine for the block ack/nack receiver.
module bagn_ctrl
    import bagn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (stat.op)
                    OP_DATA:      state_next = S_DATA;
                    OP_HEARTBEAT: state_next = S_HEARTBEAT;
                    OP_DRAIN:     state_next = S_DRAIN_SETUP;
                    OP_IDLE_TICK: state_next = S_TICK;
                    default:      state_next = S_IDLE;
                endcase
            end
            S_DATA:
            begin
                state_next = stat.data_skip ? S_IDLE : S_GAP;
            end
            S_GAP:
            begin
                state_next = stat.nack_go ? S_NACK : S_IDLE;
            end
            S_NACK:
            begin
                if (!stat.nack_more)
                begin
                    state_next = S_IDLE;
                end
            end
            S_HEARTBEAT:   state_next = S_IDLE;
            S_TICK:        state_next = S_IDLE;
            S_DRAIN_SETUP:
            begin
                state_next = stat.drain_zero ? S_IDLE : S_DRAIN_RD;
            end
            S_DRAIN_RD:    state_next = S_DRAIN_LOAD;
            S_DRAIN_LOAD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.drain_more ? S_DRAIN_RD : S_IDLE;
                end
            end
            default:       state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        in_stall        = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:        cmd.latch       = in_valid;
            S_DATA:        cmd.data_exec   = !stat.data_skip;
            S_GAP:         cmd.gap_exec    = 1'b1;
            S_NACK:        cmd.nack_push   = 1'b1;
            S_HEARTBEAT:   cmd.hb_exec     = 1'b1;
            S_TICK:        cmd.tick_exec   = 1'b1;
            S_DRAIN_SETUP: cmd.drain_setup = 1'b1;
            S_DRAIN_RD:    cmd.drain_read  = 1'b1;
            S_DRAIN_LOAD:  cmd.drain_load  = stat.out_free;
            default:       cmd             = '0;
        endcase
    end

endmodule

### rtl/core/bagn_dp.sv
// Datapath: session state, response queue pointers, configuration and output register.
module bagn_dp
    import bagn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dp_cmd_t                        cmd,
    output dp_stat_t                       stat,
    input  logic                           cfg_we,
    input  logic [CFG_IDX_W-1:0]           cfg_index,
    input  logic [CFG_W-1:0]               cfg_data,
    input  logic [1:0]                     operation,
    input  logic [SEQ_W-1:0]               seq_number,
    input  logic [ID_W-1:0]                src_system,
    input  logic [ID_W-1:0]                src_component,
    input  logic                           armed,
    output logic                           ram_we,
    output logic [$clog2(QUEUE_DEPTH)-1:0] ram_waddr,
    output logic [RESP_W-1:0]              ram_wdata,
    output logic                           ram_re,
    output logic [$clog2(QUEUE_DEPTH)-1:0] ram_raddr,
    input  logic [RESP_W-1:0]              ram_rdata,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [SEQ_W-1:0]               resp_seq,
    output logic                           is_ack,
    output logic                           last,
    output logic                           overflow
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    // Control state, cleared by reset.
    logic [GAP_W-1:0]   gap_thr_reg,   gap_thr_next;
    logic [TMO_W-1:0]   timeout_reg,   timeout_next;
    logic [DRAIN_W-1:0] drain_cfg_reg, drain_cfg_next;
    logic [ID_W-1:0]    target_reg,    target_next;
    logic [SEQ_W-1:0]   highest_reg,   highest_next;
    logic               active_reg,    active_next;
    logic [ID_W-1:0]    peer_sys_reg,  peer_sys_next;
    logic [ID_W-1:0]    peer_comp_reg, peer_comp_next;
    arm_t               arm_reg,       arm_next;
    logic [TMO_W-1:0]   idle_reg,      idle_next;
    logic [AW-1:0]      head_reg,      head_next;
    logic [AW-1:0]      tail_reg,      tail_next;
    logic [CW-1:0]      count_reg,     count_next;
    logic               drop_reg,      drop_next;
    logic               out_valid_reg, out_valid_next;
    logic [DRAIN_W-1:0] drain_left_reg, drain_left_next;

    // Payload registers.
    op_t                op_reg;
    logic [SEQ_W-1:0]   seq_reg;
    logic [ID_W-1:0]    sys_reg;
    logic [ID_W-1:0]    comp_reg;
    logic               armed_reg;
    logic [SEQ_W:0]     diff_reg;
    logic [SEQ_W-1:0]   nack_seq_reg;
    logic [GAP_W-1:0]   nack_left_reg;
    logic [SEQ_W-1:0]   resp_seq_reg;
    logic               is_ack_reg;
    logic               last_reg;
    logic               overflow_reg;

    logic               push_req;
    logic               full;
    logic               seq_gt;
    logic               gap_ok;
    logic               hb_match;
    logic [TMO_W-1:0]   idle_inc;
    logic [DRAIN_W-1:0] drain_lim;
    logic [DRAIN_W-1:0] drain_n;
    logic               out_free;

    assign push_req = cmd.data_exec || cmd.nack_push;
    assign full     = (count_reg == CNT_FULL);

    assign ram_we    = push_req && !full;
    assign ram_waddr = head_reg;
    assign ram_wdata = cmd.nack_push ? {nack_seq_reg, 1'b0} : {seq_reg, 1'b1};
    assign ram_re    = cmd.drain_read;
    assign ram_raddr = tail_reg;

    // The borrow bit of the stored difference tells whether the block lies above the
    // highest number seen.
    assign seq_gt = !diff_reg[SEQ_W] && (diff_reg[SEQ_W-1:0] != '0);
    assign gap_ok = (diff_reg[SEQ_W-1:0] <= {{(SEQ_W-GAP_W){1'b0}}, gap_thr_reg});

    assign hb_match = (sys_reg == peer_sys_reg)
                   && ((comp_reg == peer_comp_reg) || (comp_reg == target_reg));
    assign idle_inc = (idle_reg != IDLE_MAX) ? idle_reg + 1'b1 : idle_reg;

    assign drain_lim = (drain_cfg_reg > MAX_DRAIN) ? MAX_DRAIN : drain_cfg_reg;
    assign drain_n   = (count_reg < CW'(drain_lim)) ? count_reg[DRAIN_W-1:0] : drain_lim;

    assign out_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        stat            = '0;
        stat.op         = op_reg;
        stat.data_skip  = !active_reg && (seq_reg != '0);
        stat.nack_go    = seq_gt && gap_ok && (diff_reg[SEQ_W-1:0] > 32'd1);
        stat.nack_more  = (nack_left_reg != 8'd1);
        stat.drain_zero = (drain_n == '0);
        stat.drain_more = (drain_left_reg != '0);
        stat.out_free   = out_free;
    end

    always_comb
    begin
        gap_thr_next    = gap_thr_reg;
        timeout_next    = timeout_reg;
        drain_cfg_next  = drain_cfg_reg;
        target_next     = target_reg;
        highest_next    = highest_reg;
        active_next     = active_reg;
        peer_sys_next   = peer_sys_reg;
        peer_comp_next  = peer_comp_reg;
        arm_next        = arm_reg;
        idle_next       = idle_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        count_next      = count_reg;
        drop_next       = drop_reg;
        drain_left_next = drain_left_reg;
        out_valid_next  = out_valid_reg;

        if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAP:     gap_thr_next   = cfg_data[GAP_W-1:0];
                CFG_TIMEOUT: timeout_next   = cfg_data[TMO_W-1:0];
                CFG_DRAIN:   drain_cfg_next = cfg_data[DRAIN_W-1:0];
                CFG_TARGET:  target_next    = cfg_data[ID_W-1:0];
                default:     gap_thr_next   = gap_thr_reg;
            endcase
        end

        if (cmd.data_exec)
        begin
            if (!active_reg)
            begin
                peer_sys_next  = sys_reg;
                peer_comp_next = comp_reg;
                arm_next       = ARM_UNKNOWN;
                active_next    = 1'b1;
            end
            idle_next = '0;
        end

        if (cmd.gap_exec && seq_gt)
        begin
            highest_next = seq_reg;
        end

        if (push_req)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                head_next  = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
                count_next = count_reg + 1'b1;
            end
        end

        if (cmd.hb_exec && hb_match)
        begin
            if (active_reg && (arm_reg == ARM_ARMED) && !armed_reg)
            begin
                active_next = 1'b0;
            end
            arm_next = armed_reg ? ARM_ARMED : ARM_DISARMED;
        end

        if (cmd.tick_exec && active_reg)
        begin
            idle_next = idle_inc;
            if (idle_inc >= timeout_reg)
            begin
                active_next = 1'b0;
            end
        end

        if (cmd.drain_setup)
        begin
            drain_left_next = drain_n;
        end

        if (cmd.drain_read)
        begin
            tail_next       = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
            count_next      = count_reg - 1'b1;
            drain_left_next = drain_left_reg - 1'b1;
        end

        if (cmd.drain_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_thr_reg    <= GAP_RESET;
            timeout_reg    <= TIMEOUT_RESET;
            drain_cfg_reg  <= DRAIN_RESET;
            target_reg     <= TARGET_RESET;
            highest_reg    <= '0;
            active_reg     <= 1'b0;
            peer_sys_reg   <= '0;
            peer_comp_reg  <= '0;
            arm_reg        <= ARM_UNKNOWN;
            idle_reg       <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            count_reg      <= '0;
            drop_reg       <= 1'b0;
            drain_left_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            gap_thr_reg    <= gap_thr_next;
            timeout_reg    <= timeout_next;
            drain_cfg_reg  <= drain_cfg_next;
            target_reg     <= target_next;
            highest_reg    <= highest_next;
            active_reg     <= active_next;
            peer_sys_reg   <= peer_sys_next;
            peer_comp_reg  <= peer_comp_next;
            arm_reg        <= arm_next;
            idle_reg       <= idle_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            count_reg      <= count_next;
            drop_reg       <= drop_next;
            drain_left_reg <= drain_left_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg    <= op_t'(operation);
            seq_reg   <= seq_number;
            sys_reg   <= src_system;
            comp_reg  <= src_component;
            armed_reg <= armed;
        end
        if (cmd.data_exec)
        begin
            diff_reg <= {1'b0, seq_reg} - {1'b0, highest_reg};
        end
        // The nack run starts just above the old highest number and covers the gap
        // minus the block itself.
        if (cmd.gap_exec)
        begin
            nack_seq_reg  <= highest_reg + 1'b1;
            nack_left_reg <= diff_reg[GAP_W-1:0] - 1'b1;
        end
        if (cmd.nack_push)
        begin
            nack_seq_reg  <= nack_seq_reg + 1'b1;
            nack_left_reg <= nack_left_reg - 1'b1;
        end
        if (cmd.drain_load)
        begin
            resp_seq_reg <= ram_rdata[RESP_W-1:1];
            is_ack_reg   <= ram_rdata[0];
            last_reg     <= (drain_left_reg == '0);
            overflow_reg <= drop_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign resp_seq  = resp_seq_reg;
    assign is_ack    = is_ack_reg;
    assign last      = last_reg;
    assign overflow  = overflow_reg;

endmodule

### rtl/core/block_ack_gap_nack_receiver.sv
// Top level of the block ack/nack receiver: controller, datapath and response queue RAM.
//
//  Channel  Handshake             Payload
//  in       in_valid / in_stall   operation, seq_number, src_system, src_component, armed
//  out      out_valid / out_stall resp_seq, is_ack, last, overflow
//  cfg      cfg_we                cfg_index, cfg_data
//
// One item at a time. A heartbeat or idle tick is decoded and then executed; a data
// block is decoded, queues its ack, is gap-tested and then queues its nacks, one queue
// write a cycle, and a block ignored outside a session returns to idle after the check.
// A drain tick reads and loads its responses in turn through the single read port of the
// queue RAM, each load waiting on output stalls. The last response of a drain may
// wait in the output register while the next transaction is taken in.
// Reset clears all control state at once; the queue RAM needs no clearing pass.
module block_ack_gap_nack_receiver
    import bagn_pkg::*;
#(
    parameter int QUEUE_DEPTH = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [1:0]           operation,
    input  logic [SEQ_W-1:0]     seq_number,
    input  logic [ID_W-1:0]      src_system,
    input  logic [ID_W-1:0]      src_component,
    input  logic                 armed,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [SEQ_W-1:0]     resp_seq,
    output logic                 is_ack,
    output logic                 last,
    output logic                 overflow,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int AW = $clog2(QUEUE_DEPTH);

    dp_cmd_t           cmd;
    dp_stat_t          stat;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [RESP_W-1:0] ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [RESP_W-1:0] ram_rdata;

    bagn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bagn_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .operation     (operation),
        .seq_number    (seq_number),
        .src_system    (src_system),
        .src_component (src_component),
        .armed         (armed),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata),
        .ram_re        (ram_re),
        .ram_raddr     (ram_raddr),
        .ram_rdata     (ram_rdata),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .resp_seq      (resp_seq),
        .is_ack        (is_ack),
        .last          (last),
        .overflow      (overflow)
    );

    bagn_ram #(
        .WIDTH (RESP_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

endmodule

### test/tb_block_ack_gap_nack_receiver.sv
// Self-checking testbench for the block ack/nack receiver with a built-in response predictor.
module tb_block_ack_gap_nack_receiver;
    import bagn_pkg::*;

    localparam int DEPTH         = 256;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS  = 230;

    typedef struct {
        op_t              op;
        logic [SEQ_W-1:0] seq;
        logic [ID_W-1:0]  sys;
        logic [ID_W-1:0]  comp;
        logic             arm_flag;
    } link_item_t;

    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic             ack;
    } held_resp_t;

    typedef struct {
        logic [SEQ_W-1:0] seq;
        logic             ack;
        logic             last_flag;
        logic             ovf;
    } drain_resp_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 in_valid      = 1'b0;
    logic                 in_stall;
    logic [1:0]           operation     = OP_DATA;
    logic [SEQ_W-1:0]     seq_number    = '0;
    logic [ID_W-1:0]      src_system    = '0;
    logic [ID_W-1:0]      src_component = '0;
    logic                 armed         = 1'b0;
    logic                 out_valid;
    logic                 out_stall     = 1'b0;
    logic [SEQ_W-1:0]     resp_seq;
    logic                 is_ack;
    logic                 last;
    logic                 overflow;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index     = CFG_GAP;
    logic [CFG_W-1:0]     cfg_data      = '0;

    block_ack_gap_nack_receiver i_dut (.*);

    // Predicted receiver state and register copies.
    logic [GAP_W-1:0]   gap_lim    = GAP_RESET;
    logic [TMO_W-1:0]   tmo_lim    = TIMEOUT_RESET;
    logic [DRAIN_W-1:0] drain_cfg  = DRAIN_RESET;
    logic [ID_W-1:0]    tgt_comp   = TARGET_RESET;
    logic [SEQ_W-1:0]   hi_seq     = '0;
    logic               in_session = 1'b0;
    logic [ID_W-1:0]    peer_sys   = '0;
    logic [ID_W-1:0]    peer_comp  = '0;
    arm_t               arm_st     = ARM_UNKNOWN;
    logic [TMO_W-1:0]   idle_ticks = '0;
    logic               drop_seen  = 1'b0;

    held_resp_t  held_responses[$];
    drain_resp_t due_responses[$];
    link_item_t  item_backlog[$];

    link_item_t  cur_item;
    drain_resp_t want_resp;
    int          errors     = 0;
    int          n_in       = 0;
    int          n_checked  = 0;
    int          n_settings = 0;
    int          n_random   = 0;
    logic        quiet      = 1'b0;
    int unsigned send_hold  = 0;
    int unsigned stall_left = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    initial begin
        #24_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(string what, logic [SEQ_W-1:0] want, logic [SEQ_W-1:0] got);
        $display("mismatch at %0t: %s expected %0h, got %0h", $time, what, want, got);
        errors++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int unsigned drain_limit();
        return (drain_cfg > MAX_DRAIN) ? MAX_DRAIN : drain_cfg;
    endfunction

    function automatic void queue_resp(logic [SEQ_W-1:0] s, logic ack);
        if (held_responses.size() >= DEPTH)
            drop_seen = 1'b1;
        else
            held_responses.push_back('{s, ack});
    endfunction

    function automatic void advance_receiver(link_item_t it);
        logic [SEQ_W-1:0] s;
        held_resp_t       h;
        int unsigned      n;
        case (it.op)
            OP_DATA: begin
                if (!in_session) begin
                    if (it.seq != '0)
                        return;
                    peer_sys   = it.sys;
                    peer_comp  = it.comp;
                    arm_st     = ARM_UNKNOWN;
                    in_session = 1'b1;
                end
                idle_ticks = '0;
                queue_resp(it.seq, 1'b1);
                if (it.seq > hi_seq) begin
                    if (it.seq - hi_seq <= gap_lim)
                        for (s = hi_seq + 1; s < it.seq; s++)
                            queue_resp(s, 1'b0);
                    hi_seq = it.seq;
                end
            end
            OP_HEARTBEAT: begin
                if (it.sys == peer_sys && (it.comp == peer_comp || it.comp == tgt_comp)) begin
                    if (in_session && arm_st == ARM_ARMED && !it.arm_flag)
                        in_session = 1'b0;
                    arm_st = it.arm_flag ? ARM_ARMED : ARM_DISARMED;
                end
            end
            OP_DRAIN: begin
                n = (held_responses.size() < drain_limit()) ? held_responses.size()
                                                            : drain_limit();
                for (int k = 0; k < n; k++) begin
                    h = held_responses.pop_front();
                    due_responses.push_back('{h.seq, h.ack, k == n - 1, drop_seen});
                end
            end
            default: begin
                if (in_session) begin
                    if (idle_ticks != IDLE_MAX)
                        idle_ticks++;
                    if (idle_ticks >= tmo_lim)
                        in_session = 1'b0;
                end
            end
        endcase
    endfunction

    // Sender: presents queued items, predicts on each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            send_hold <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                advance_receiver(cur_item);
                n_in++;
            end
            if (!in_valid || !in_stall)
            begin
                if (send_hold != 0)
                begin
                    send_hold <= send_hold - 1;
                    in_valid  <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    cur_item = item_backlog.pop_front();
                    operation     <= cur_item.op;
                    seq_number    <= cur_item.seq;
                    src_system    <= cur_item.sys;
                    src_component <= cur_item.comp;
                    armed         <= cur_item.arm_flag;
                    in_valid      <= 1'b1;
                    send_hold     <= pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random back-pressure, checks each response against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_responses.size() == 0)
                begin
                    report_mismatch("response with nothing pending, resp_seq", '0, resp_seq);
                end
                else
                begin
                    want_resp = due_responses.pop_front();
                    n_checked++;
                    if (resp_seq !== want_resp.seq)
                        report_mismatch("resp_seq", want_resp.seq, resp_seq);
                    if (is_ack !== want_resp.ack)
                        report_mismatch("is_ack", want_resp.ack, is_ack);
                    if (last !== want_resp.last_flag)
                        report_mismatch("last", want_resp.last_flag, last);
                    if (overflow !== want_resp.ovf)
                        report_mismatch("overflow", want_resp.ovf, overflow);
                end
            end
            if (stall_left != 0)
            begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else
            begin
                out_stall  <= 1'b0;
                stall_left <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    task automatic queue_item(op_t op, logic [SEQ_W-1:0] s, logic [ID_W-1:0] sys,
                              logic [ID_W-1:0] comp, logic a);
        item_backlog.push_back('{op, s, sys, comp, a});
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_GAP:     gap_lim   = val[GAP_W-1:0];
            CFG_TIMEOUT: tmo_lim   = val[TMO_W-1:0];
            CFG_DRAIN:   drain_cfg = val[DRAIN_W-1:0];
            default:     tgt_comp  = val[ID_W-1:0];
        endcase
        n_settings++;
    endtask

    // Blocks until every transaction is taken and every predicted response seen,
    // then leaves time for a long nack burst that produces no response.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (item_backlog.size() != 0 || in_valid || due_responses.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic settle_link();
        int unsigned ticks;
        wait_drained();
        if (held_responses.size() != 0)
        begin
            if (drain_limit() == 0)
                write_reg(CFG_DRAIN, MAX_DRAIN);
            ticks = (held_responses.size() + drain_limit() - 1) / drain_limit();
            repeat (ticks)
                queue_item(OP_DRAIN, $urandom(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
            wait_drained();
        end
    endtask

    task automatic shuffle_settings();
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 4))
                0:       write_reg(CFG_GAP, 0);
                1:       write_reg(CFG_GAP, 255);
                2:       write_reg(CFG_GAP, GAP_RESET);
                default: write_reg(CFG_GAP, $urandom_range(0, 255));
            endcase
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TIMEOUT, 0);
                1:       write_reg(CFG_TIMEOUT, 1);
                2:       write_reg(CFG_TIMEOUT, 16'hFFFF);
                3:       write_reg(CFG_TIMEOUT, $urandom_range(2, 6));
                default: write_reg(CFG_TIMEOUT, $urandom_range(4, 40));
            endcase
        if ($urandom_range(0, 1))
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_DRAIN, 0);
                1:       write_reg(CFG_DRAIN, $urandom_range(9, 15));
                2:       write_reg(CFG_DRAIN, MAX_DRAIN);
                3:       write_reg(CFG_DRAIN, 1);
                default: write_reg(CFG_DRAIN, $urandom_range(1, 8));
            endcase
        if ($urandom_range(0, 1))
            write_reg(CFG_TARGET, $urandom_range(0, 255));
    endtask

    // Mostly well-formed sessions with random content, sprinkled with noise.
    task automatic run_random_phase();
        logic             g_active;
        logic             g_arm;
        logic             a;
        logic [SEQ_W-1:0] g_hi;
        logic [SEQ_W-1:0] s;
        logic [SEQ_W-1:0] gap;
        logic [ID_W-1:0]  g_sys;
        logic [ID_W-1:0]  g_comp;
        int unsigned      g_idle;
        int unsigned      est;
        int unsigned      r;
        int unsigned      x;
        int unsigned      n_items;
        op_t              op;
        g_active = in_session;
        g_arm    = (arm_st == ARM_ARMED);
        g_hi     = hi_seq;
        g_sys    = peer_sys;
        g_comp   = peer_comp;
        g_idle   = idle_ticks;
        est      = 0;
        quiet    = ($urandom_range(0, 3) == 0);
        n_items  = $urandom_range(8, 16);
        for (int k = 0; k < n_items; k++)
        begin
            r = $urandom_range(0, 99);
            if (!g_active && $urandom_range(0, 9) != 0)
            begin
                g_sys  = $urandom_range(0, 255);
                g_comp = $urandom_range(0, 255);
                queue_item(OP_DATA, '0, g_sys, g_comp, $urandom_range(0, 1));
                g_active = 1'b1;
                g_arm    = 1'b0;
                g_idle   = 0;
                est++;
                n_random++;
            end
            else if ((est > 200 && drain_limit() != 0) || (r >= 45 && r < 65))
            begin
                queue_item(OP_DRAIN, $urandom(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
                est = (est > drain_limit()) ? est - drain_limit() : 0;
                n_random++;
            end
            else if (r < 45)
            begin
                x = $urandom_range(0, 99);
                if (x < 65)
                    gap = 1;
                else if (x < 80)
                    gap = $urandom_range(2, 5);
                else if (x < 90)
                    gap = $urandom_range(6, 24);
                else if (x < 95)
                    gap = 0;
                else
                    gap = gap_lim + $urandom_range(1, 40);
                if (gap == 0)
                begin
                    x = $urandom_range(0, 10);
                    s = (x > g_hi) ? '0 : g_hi - x;
                    est++;
                end
                else
                begin
                    s = g_hi + gap;
                    est += 1 + ((gap <= gap_lim && gap > 1) ? gap - 1 : 0);
                    if (s > g_hi)
                        g_hi = s;
                end
                queue_item(OP_DATA, s, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 1));
                if (g_active)
                    n_random++;
                g_idle = 0;
            end
            else if (r < 75)
            begin
                queue_item(OP_IDLE_TICK, $urandom(), $urandom_range(0, 255),
                           $urandom_range(0, 255), $urandom_range(0, 1));
                g_idle++;
                if (g_idle >= tmo_lim)
                    g_active = 1'b0;
                n_random++;
            end
            else if (r < 87)
            begin
                a = g_arm ? $urandom_range(0, 1) : ($urandom_range(0, 3) != 0);
                queue_item(OP_HEARTBEAT, $urandom(), g_sys,
                           $urandom_range(0, 1) ? g_comp : tgt_comp, a);
                if (g_arm && !a)
                    g_active = 1'b0;
                g_arm = a;
                n_random++;
            end
            else
            begin
                op = op_t'($urandom_range(0, 3));
                s  = $urandom();
                // Keep stray in-session blocks in the lower half so sessions can go on.
                if (op == OP_DATA && g_active)
                    s = s >> 1;
                queue_item(op, s, $urandom_range(0, 255), $urandom_range(0, 255),
                           $urandom_range(0, 1));
                if (op != OP_DATA || g_active)
                    n_random++;
            end
        end
        settle_link();
    endtask

    initial
    begin
        logic [SEQ_W-1:0] h;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: session start rules, gap nacks, duplicate, drains, disarm.
        queue_item(OP_DATA, 7, 8'h01, 8'h02, 1'b0);
        queue_item(OP_HEARTBEAT, 0, 8'h00, 8'h00, 1'b1);
        queue_item(OP_DATA, 0, 8'hFF, 8'h00, 1'b0);
        queue_item(OP_DATA, 4, 8'h12, 8'h34, 1'b1);
        queue_item(OP_DATA, 2, 8'h00, 8'hFF, 1'b0);
        queue_item(OP_DRAIN, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
        queue_item(OP_DRAIN, 0, 8'h00, 8'h00, 1'b0);
        queue_item(OP_DRAIN, 0, 8'h00, 8'h00, 1'b0);
        queue_item(OP_HEARTBEAT, 0, 8'hFF, 8'h00, 1'b1);
        queue_item(OP_HEARTBEAT, 0, 8'hFF, 8'h55, 1'b0);
        queue_item(OP_HEARTBEAT, 0, 8'hFF, 8'h00, 1'b0);
        queue_item(OP_DATA, 9, 8'hFF, 8'h00, 1'b0);
        settle_link();

        // Widest gap, saturating drain limit, zero timeout, heartbeats via the target id.
        write_reg(CFG_GAP, 255);
        write_reg(CFG_DRAIN, 15);
        write_reg(CFG_TIMEOUT, 0);
        write_reg(CFG_TARGET, 8'h3C);
        queue_item(OP_DATA, 0, 8'h00, 8'hFF, 1'b0);
        queue_item(OP_DATA, 60, 8'hA5, 8'h5A, 1'b1);
        queue_item(OP_DRAIN, 0, 8'h00, 8'h00, 1'b0);
        queue_item(OP_IDLE_TICK, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 1'b1);
        queue_item(OP_DATA, 3, 8'h00, 8'hFF, 1'b0);
        queue_item(OP_HEARTBEAT, 0, 8'h00, 8'h3C, 1'b1);
        queue_item(OP_HEARTBEAT, 0, 8'h00, 8'h3C, 1'b0);
        settle_link();

        // No gap allowed, drain limit of zero, single-tick timeout.
        write_reg(CFG_GAP, 0);
        write_reg(CFG_DRAIN, 0);
        write_reg(CFG_TIMEOUT, 1);
        write_reg(CFG_TARGET, TARGET_RESET);
        queue_item(OP_DATA, 0, 8'h05, 8'h06, 1'b0);
        queue_item(OP_DATA, 61, 8'h05, 8'h06, 1'b0);
        queue_item(OP_DATA, 63, 8'h05, 8'h06, 1'b0);
        queue_item(OP_DRAIN, 0, 8'h00, 8'h00, 1'b0);
        queue_item(OP_IDLE_TICK, 0, 8'h00, 8'h00, 1'b0);
        settle_link();

        while (n_random < RANDOM_ITEMS)
        begin
            shuffle_settings();
            run_random_phase();
        end

        // Fill the response queue exactly, then overflow it; the drop flag is sticky.
        write_reg(CFG_GAP, 255);
        write_reg(CFG_DRAIN, MAX_DRAIN);
        write_reg(CFG_TIMEOUT, 16'hFFFF);
        h = hi_seq;
        queue_item(OP_DATA, 0, 8'h11, 8'h22, 1'b0);
        queue_item(OP_DATA, h + 255, 8'h11, 8'h22, 1'b0);
        queue_item(OP_DATA, h + 255, 8'h11, 8'h22, 1'b0);
        settle_link();
        queue_item(OP_DATA, 32'hFFFF_FFFF, 8'h11, 8'h22, 1'b1);
        settle_link();

        $display("Run covered %0d input transactions and %0d checked responses,",
                 n_in, n_checked);
        $display("%0d register writes; full-queue drop %s reached.",
                 n_settings, drop_seen ? "was" : "was not");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/core/bagn_pkg.sv
rtl/core/bagn_ram.sv
rtl/core/bagn_ctrl.sv
rtl/core/bagn_dp.sv
rtl/core/block_ack_gap_nack_receiver.sv
test/tb_block_ack_gap_nack_receiver.sv
